### rtl/frr_pkg.sv
// Shared types and constants for the right-angle frame rotator.
package frr_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_DATA_W-1:0] CFG_DIM_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION = 2'd0,
    REG_WIDTH    = 2'd1,
    REG_HEIGHT   = 2'd2
  } cfg_reg_e;

  // rotation codes; the unused code acts as 270
  localparam logic [1:0] ROT_90  = 2'd0;
  localparam logic [1:0] ROT_180 = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd2;
  localparam logic [1:0] ROT_SAT = 2'd3;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_NOT_READY = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_ADDR = 5'b00100,
    S_READ = 5'b01000,
    S_RESP = 5'b10000
  } frr_state_e;

  typedef struct packed {
    logic capture;
    logic load_write;
    logic fetch_addr;
    logic fetch_nr;
    logic mem_read;
    logic resp_load;
  } frr_cmd_t;

  typedef struct packed {
    logic frame_ready;
    logic out_free;
  } frr_stat_t;

endpackage

### rtl/frr_ctrl.sv
// Sequencer for load and fetch words of the frame rotator.
module frr_ctrl import frr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      op_i,
  output logic      in_ready_o,
  input  frr_stat_t stat_i,
  output frr_cmd_t  cmd_o
);

  frr_state_e state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          if (op_i == OP_LOAD) begin
            state_d = S_LOAD;
          end else if (stat_i.frame_ready) begin
            state_d = S_ADDR;
          end else begin
            cmd_o.fetch_nr = 1'b1;
            state_d        = S_RESP;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_write = 1'b1;
        state_d          = S_IDLE;
      end
      S_ADDR: begin
        cmd_o.fetch_addr = 1'b1;
        state_d          = S_READ;
      end
      S_READ: begin
        cmd_o.mem_read = 1'b1;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/frr_datapath.sv
// Frame store, counters, rotated address generation and output register.
module frr_datapath import frr_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  input  frr_cmd_t              cmd_i,
  output frr_stat_t             stat_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  last_o,
  output logic                  status_o
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW      = $clog2(MAX_DIM);
  localparam int DW      = $clog2(MAX_DIM + 1);
  localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW      = $clog2(DEPTH);

  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v,
                                              input int unsigned mx);
    logic [DW-1:0] r;
    if (v == '0) begin
      r = DW'(1);
    end else if (32'(v) > mx) begin
      r = DW'(mx);
    end else begin
      r = DW'(v);
    end
    return r;
  endfunction

  logic [1:0]            rot_q;
  logic [DW-1:0]         width_q, height_q;
  logic [CW-1:0]         ld_row_q, ld_col_q, out_row_q, out_col_q;
  logic                  ready_q;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [AW-1:0]         rd_addr_q;
  logic [PIXEL_BITS-1:0] rd_data_q;
  logic                  last_q;
  logic                  resp_stat_q;
  logic                  out_valid_q;
  logic [PIXEL_BITS-1:0] out_pix_q;
  logic                  out_last_q;
  logic                  out_stat_q;

  logic [PIXEL_BITS-1:0] mem [DEPTH];

  logic [1:0]    rot_eff;
  logic          ld_wrap;
  logic [CW-1:0] ld_row_eff, ld_col_eff;
  logic [DW-1:0] ld_col_nx, ld_row_nx;
  logic          ld_col_end, ld_row_end;
  logic [AW-1:0] wr_addr;

  logic [DW-1:0] rows, cols;
  logic          o_wrap;
  logic [CW-1:0] o_row_eff, o_col_eff;
  logic [DW-1:0] sr, sc;
  logic [DW-1:0] o_col_nx, o_row_nx;
  logic          o_col_end, o_row_end;
  logic          is_last;
  logic [AW-1:0] rd_addr_d;

  assign rot_eff = (rot_q == ROT_SAT) ? ROT_270 : rot_q;

  // load side: a load after a ready frame, or with counters past the size, restarts at 0
  assign ld_wrap    = ready_q || (DW'(ld_row_q) >= height_q) || (DW'(ld_col_q) >= width_q);
  assign ld_row_eff = ld_wrap ? '0 : ld_row_q;
  assign ld_col_eff = ld_wrap ? '0 : ld_col_q;
  assign ld_col_nx  = DW'(ld_col_eff) + DW'(1);
  assign ld_row_nx  = DW'(ld_row_eff) + DW'(1);
  assign ld_col_end = (ld_col_nx >= width_q);
  assign ld_row_end = (ld_row_nx >= height_q);
  assign wr_addr    = AW'(ld_row_eff) * AW'(MAX_WIDTH) + AW'(ld_col_eff);

  // fetch side
  assign rows      = (rot_eff == ROT_180) ? height_q : width_q;
  assign cols      = (rot_eff == ROT_180) ? width_q : height_q;
  assign o_wrap    = (DW'(out_row_q) >= rows) || (DW'(out_col_q) >= cols);
  assign o_row_eff = o_wrap ? '0 : out_row_q;
  assign o_col_eff = o_wrap ? '0 : out_col_q;
  assign o_col_nx  = DW'(o_col_eff) + DW'(1);
  assign o_row_nx  = DW'(o_row_eff) + DW'(1);
  assign o_col_end = (o_col_nx >= cols);
  assign o_row_end = (o_row_nx >= rows);
  assign is_last   = (DW'(o_col_eff) == cols - DW'(1)) && (DW'(o_row_eff) == rows - DW'(1));

  always_comb begin
    case (rot_eff)
      ROT_90: begin
        sr = height_q - DW'(1) - DW'(o_col_eff);
        sc = DW'(o_row_eff);
      end
      ROT_180: begin
        sr = height_q - DW'(1) - DW'(o_row_eff);
        sc = width_q - DW'(1) - DW'(o_col_eff);
      end
      default: begin
        sr = DW'(o_col_eff);
        sc = width_q - DW'(1) - DW'(o_row_eff);
      end
    endcase
  end

  assign rd_addr_d = AW'(sr[CW-1:0]) * AW'(MAX_WIDTH) + AW'(sc[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q     <= ROT_90;
      width_q   <= clamp_dim(CFG_DIM_RESET, MAX_WIDTH);
      height_q  <= clamp_dim(CFG_DIM_RESET, MAX_HEIGHT);
      ld_row_q  <= '0;
      ld_col_q  <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      ready_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_ROTATION: begin
          rot_q     <= cfg_data_i[1:0];
          out_row_q <= '0;
          out_col_q <= '0;
        end
        REG_WIDTH, REG_HEIGHT: begin
          if (cfg_reg_e'(cfg_index_i) == REG_WIDTH) begin
            width_q <= clamp_dim(cfg_data_i, MAX_WIDTH);
          end else begin
            height_q <= clamp_dim(cfg_data_i, MAX_HEIGHT);
          end
          ld_row_q  <= '0;
          ld_col_q  <= '0;
          out_row_q <= '0;
          out_col_q <= '0;
          ready_q   <= 1'b0;
        end
        default: begin
        end
      endcase
    end else if (cmd_i.load_write) begin
      ready_q <= ld_col_end && ld_row_end;
      if (ld_col_end) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_end ? '0 : ld_row_nx[CW-1:0];
        if (ld_row_end) begin
          out_row_q <= '0;
          out_col_q <= '0;
        end
      end else begin
        ld_col_q <= ld_col_nx[CW-1:0];
        ld_row_q <= ld_row_eff;
      end
    end else if (cmd_i.fetch_addr) begin
      if (o_col_end) begin
        out_col_q <= '0;
        out_row_q <= o_row_end ? '0 : o_row_nx[CW-1:0];
      end else begin
        out_col_q <= o_col_nx[CW-1:0];
        out_row_q <= o_row_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pix_q <= pixel_in_i;
    end
    if (cmd_i.fetch_addr) begin
      rd_addr_q   <= rd_addr_d;
      last_q      <= is_last;
      resp_stat_q <= ST_OK;
    end else if (cmd_i.fetch_nr) begin
      resp_stat_q <= ST_NOT_READY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_write) begin
      mem[wr_addr] <= pix_q;
    end
    if (cmd_i.mem_read) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  // output register: parts the sequencer from the consumer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.resp_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.resp_load) begin
      out_stat_q <= resp_stat_q;
      out_pix_q  <= (resp_stat_q == ST_NOT_READY) ? '0 : rd_data_q;
      out_last_q <= (resp_stat_q == ST_NOT_READY) ? 1'b0 : last_q;
    end
  end

  assign stat_o.frame_ready = ready_q;
  assign stat_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = out_pix_q;
  assign last_o      = out_last_q;
  assign status_o    = out_stat_q;

endmodule

### rtl/frame_rotate_right_angle.sv
// Top level of the right-angle frame rotator.
// Load words write source pixels in raster order into a single-port frame store of
// MAX_WIDTH*MAX_HEIGHT entries; after width*height loads the frame is ready. Fetch
// words return the frame rotated by 90, 180 or 270 degrees in raster order, with last
// on the final pixel, wrapping to reread. A load is accepted, then written; a fetch is
// accepted, then passes address generation, a registered store read and the output
// load, plus any wait for the output register to drain; a fetch on a frame that is not
// ready goes from accept to output load and returns status not_ready. One word is in
// flight at a time, set by the sequencing through the one store port with registered
// address and read data. The store is not cleared after reset. Configuration writes
// are accepted every cycle and must be made while the block is idle.
module frame_rotate_right_angle import frr_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [PIXEL_BITS-1:0] pixel_in_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [PIXEL_BITS-1:0] pixel_out_o,
  output logic                  last_o,
  output logic                  status_o
);

  frr_cmd_t  cmd;
  frr_stat_t stat;

  assign cfg_ready_o = 1'b1;

  frr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  frr_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pixel_in_i  (pixel_in_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule

### rtl/frr_checker.sv
// Port-level checks for the frame rotator, bound to the top level.
module frr_checker import frr_pkg::*; #(
  parameter int PIXEL_BITS = 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  op_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [PIXEL_BITS-1:0] pixel_out_o,
  input logic                  last_o,
  input logic                  status_o
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o)
                                    && $stable(last_o) && $stable(status_o))
    else $error("output word changed while stalled");

  // a not-ready answer carries no pixel and no frame end
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NOT_READY) |-> (pixel_out_o == '0) && !last_o)
    else $error("not-ready word carries data");

  // a load word never raises a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (op_i == OP_LOAD) && !out_valid_o |=> !out_valid_o)
    else $error("load word produced a result");

  // no new word is taken in the cycle after one was accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while busy");

endmodule

bind frame_rotate_right_angle frr_checker #(.PIXEL_BITS(PIXEL_BITS)) u_frr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .op_i        (op_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .pixel_out_o (pixel_out_o),
  .last_o      (last_o),
  .status_o    (status_o)
);
